/* sv/lidar_polar_to_cartesian_unit_macros.svh */
`ifndef LIDAR_POLAR_TO_CARTESIAN_UNIT_MACROS_SVH
`define LIDAR_POLAR_TO_CARTESIAN_UNIT_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define LP2C_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while dis is high.
`define LP2C_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lp2c_pkg.sv */
`timescale 1ns / 1ps

package lp2c_pkg;

    localparam int RANGE_W      = 24;
    localparam int IDX_W        = 12;
    localparam int ANGLE_W      = 16;
    localparam int COORD_W      = 25;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;
    localparam int GAIN_W       = 30;
    localparam int MAG_W        = RANGE_W + GAIN_W;
    localparam int VEC_W        = 57;
    localparam int ANG_W        = 33;
    localparam int FRAC_SH      = 30;
    localparam int CORDIC_STEPS = 28;
    localparam int MAX_BEAMS_DEF = 4096;

    localparam logic [GAIN_W-1:0]  GAIN_Q30    = 30'd652032875;
    localparam logic [COORD_W-1:0] COORD_LIMIT = 25'd16777215;
    localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 24'hFFFFFF;

    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_ANGLE     = 2'd0,
        REG_ANGLE_INCREMENT = 2'd1,
        REG_MIN_RANGE       = 2'd2,
        REG_MAX_RANGE       = 2'd3
    } t_reg_idx;

    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic signed [ANG_W-1:0] t_ang;

    typedef struct packed {
        logic valid;
        logic in_range;
        logic last;
    } t_side;

    typedef struct packed {
        logic [ANGLE_W-1:0]        start_angle;
        logic signed [ANGLE_W-1:0] angle_increment;
        logic [RANGE_W-1:0]        min_range;
        logic [RANGE_W-1:0]        max_range;
    } t_cfg;

endpackage

/* sv/lp2c_cell.sv */
`timescale 1ns / 1ps

module lp2c_cell #(
    parameter int STEP = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  lp2c_pkg::t_vec  i_x,
    input  lp2c_pkg::t_vec  i_y,
    input  lp2c_pkg::t_ang  i_z,
    input  lp2c_pkg::t_side i_side,
    output lp2c_pkg::t_vec  o_x,
    output lp2c_pkg::t_vec  o_y,
    output lp2c_pkg::t_ang  o_z,
    output lp2c_pkg::t_side o_side
);
    import lp2c_pkg::*;

    t_vec  r_x, r_y, n_x, n_y;
    t_ang  r_z, n_z;
    t_side r_side;
    t_ang  w_atan;

    assign w_atan = t_ang'(ATAN_TURN[STEP]);

    always_comb begin
        if (!i_z[ANG_W-1]) begin
            n_x = i_x - (i_y >>> STEP);
            n_y = i_y + (i_x >>> STEP);
            n_z = i_z - w_atan;
        end else begin
            n_x = i_x + (i_y >>> STEP);
            n_y = i_y - (i_x >>> STEP);
            n_z = i_z + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_adv) begin
            r_side.valid <= i_side.valid;
        end
        if (i_adv) begin
            r_x             <= n_x;
            r_y             <= n_y;
            r_z             <= n_z;
            r_side.in_range <= i_side.in_range;
            r_side.last     <= i_side.last;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = r_side;

endmodule

/* sv/lp2c_front.sv */
`timescale 1ns / 1ps

module lp2c_front #(
    parameter int MAX_BEAMS = lp2c_pkg::MAX_BEAMS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic                           i_valid,
    input  logic [lp2c_pkg::RANGE_W-1:0]   i_range_sample,
    input  logic [lp2c_pkg::IDX_W-1:0]     i_beam_index,
    input  logic                           i_last_in,
    input  lp2c_pkg::t_cfg                 i_cfg,
    output lp2c_pkg::t_vec                 o_x,
    output lp2c_pkg::t_vec                 o_y,
    output lp2c_pkg::t_ang                 o_z,
    output lp2c_pkg::t_side                o_side
);
    import lp2c_pkg::*;

    localparam int RECIP_SH = 24;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / MAX_BEAMS);
    localparam int QPROD_W  = IDX_W + RECIP_W;
    localparam int MB_W     = $clog2(MAX_BEAMS + 1);
    localparam int CMP_W    = IDX_W + MB_W;

    t_side              r1_side, r2_side, r3_side, r4_side;
    logic [IDX_W-1:0]   r1_idx, r1_q, r2_rem;
    logic [MAG_W-1:0]   r1_mag, r2_mag, r3_mag;
    logic [ANGLE_W-1:0] r3_angle;
    t_vec               r4_x, r4_y, n4_x, n4_y;
    t_ang               r4_z;

    logic               n1_in_range;
    logic [QPROD_W-1:0] n1_qprod;
    logic [MAG_W-1:0]   n1_mag;
    logic [CMP_W-1:0]   n2_qm;
    logic [IDX_W-1:0]   n2_diff, n2_rem;
    logic [ANGLE_W-1:0] n3_angle;
    t_vec               w_mag;

    always_comb begin
        n1_in_range = (i_range_sample >= i_cfg.min_range)
                   && (i_range_sample <= i_cfg.max_range);
        n1_qprod    = QPROD_W'(i_beam_index) * QPROD_W'(RECIP);
        n1_mag      = MAG_W'(i_range_sample) * MAG_W'(GAIN_Q30);
    end

    always_comb begin
        n2_qm   = CMP_W'(r1_q) * CMP_W'(MAX_BEAMS);
        n2_diff = r1_idx - IDX_W'(n2_qm);
        if (CMP_W'(n2_diff) >= CMP_W'(MAX_BEAMS)) begin
            n2_rem = n2_diff - IDX_W'(MAX_BEAMS);
        end else begin
            n2_rem = n2_diff;
        end
    end

    always_comb begin
        n3_angle = i_cfg.start_angle
                 + ANGLE_W'(32'(r2_rem) * 32'($unsigned(i_cfg.angle_increment)));
    end

    assign w_mag = t_vec'(r3_mag);

    always_comb begin
        case (r3_angle[ANGLE_W-1 -: 2])
            2'd0: begin
                n4_x = w_mag;
                n4_y = '0;
            end
            2'd1: begin
                n4_x = '0;
                n4_y = w_mag;
            end
            2'd2: begin
                n4_x = -w_mag;
                n4_y = '0;
            end
            default: begin
                n4_x = '0;
                n4_y = -w_mag;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_side.valid <= 1'b0;
            r2_side.valid <= 1'b0;
            r3_side.valid <= 1'b0;
            r4_side.valid <= 1'b0;
        end else if (i_adv) begin
            r1_side.valid <= i_valid;
            r2_side.valid <= r1_side.valid;
            r3_side.valid <= r2_side.valid;
            r4_side.valid <= r3_side.valid;
        end
        if (i_adv) begin
            r1_side.in_range <= n1_in_range;
            r1_side.last     <= i_last_in;
            r1_idx           <= i_beam_index;
            r1_q             <= n1_qprod[RECIP_SH +: IDX_W];
            r1_mag           <= n1_mag;

            r2_side.in_range <= r1_side.in_range;
            r2_side.last     <= r1_side.last;
            r2_rem           <= n2_rem;
            r2_mag           <= r1_mag;

            r3_side.in_range <= r2_side.in_range;
            r3_side.last     <= r2_side.last;
            r3_angle         <= n3_angle;
            r3_mag           <= r2_mag;

            r4_side.in_range <= r3_side.in_range;
            r4_side.last     <= r3_side.last;
            r4_x             <= n4_x;
            r4_y             <= n4_y;
            r4_z             <= t_ang'({r3_angle[ANGLE_W-3:0], 16'h0000});
        end
    end

    assign o_x    = r4_x;
    assign o_y    = r4_y;
    assign o_z    = r4_z;
    assign o_side = r4_side;

endmodule

/* sv/lp2c_out.sv */
`timescale 1ns / 1ps

module lp2c_out (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  lp2c_pkg::t_vec                      i_x,
    input  lp2c_pkg::t_vec                      i_y,
    input  lp2c_pkg::t_side                     i_side,
    output logic                                o_out_valid,
    output logic signed [lp2c_pkg::COORD_W-1:0] o_point_x,
    output logic signed [lp2c_pkg::COORD_W-1:0] o_point_y,
    output logic                                o_point_valid,
    output logic                                o_last_out
);
    import lp2c_pkg::*;

    localparam int RND_W = VEC_W - FRAC_SH;

    logic                      r_valid, r_point_valid, r_last;
    logic signed [COORD_W-1:0] r_x, r_y, n_x, n_y;

    function automatic logic signed [COORD_W-1:0] round_sat(input t_vec v);
        t_vec                    s;
        logic signed [RND_W-1:0] q;
        logic signed [RND_W-1:0] lim;
        begin
            s   = v + t_vec'(64'd1 << (FRAC_SH - 1));
            q   = RND_W'(s >>> FRAC_SH);
            lim = RND_W'(COORD_LIMIT);
            if (q > lim) begin
                round_sat = COORD_LIMIT;
            end else if (q < -lim) begin
                round_sat = -$signed(COORD_LIMIT);
            end else begin
                round_sat = COORD_W'(q);
            end
        end
    endfunction

    always_comb begin
        if (i_side.in_range) begin
            n_x = round_sat(i_x);
            n_y = round_sat(i_y);
        end else begin
            n_x = '0;
            n_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x           <= n_x;
            r_y           <= n_y;
            r_point_valid <= i_side.in_range;
            r_last        <= i_side.last;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_point_x     = r_x;
    assign o_point_y     = r_y;
    assign o_point_valid = r_point_valid;
    assign o_last_out    = r_last;

endmodule

/* sv/lidar_polar_to_cartesian_unit.sv */
// Lidar beam to planar point.
// Input channel: i_in_valid / o_in_stall carry one beam request (range sample,
// beam index, last flag). Output channel: o_out_valid / i_out_stall carry one
// point (x, y, valid flag, last flag) per beam, in request order.
// Configuration: write i_cfg_data to register i_cfg_index while i_cfg_we is
// high; 0 start angle, 1 angle increment, 2 min range, 3 max range. Write
// only while no request is in flight.
// Pipeline: a four-stage front end (range check and gain multiply, index
// reduction, beam angle, quadrant select), a row of 28 CORDIC rotation
// cells, one round and saturate stage into the output register.
// Throughput: one beam per cycle unless stalled; every stage advances together.
// Stall: while the output register holds an untaken point and i_out_stall is
// high, the whole row holds and o_in_stall is raised.
// Reset: clears all stage valid bits and loads the register defaults
// (start 0, increment 0, min 0, max 16777215).
`timescale 1ns / 1ps

module lidar_polar_to_cartesian_unit #(
    parameter int MAX_BEAMS = lp2c_pkg::MAX_BEAMS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lp2c_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lp2c_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [lp2c_pkg::RANGE_W-1:0]        i_range_sample,
    input  logic [lp2c_pkg::IDX_W-1:0]          i_beam_index,
    input  logic                                i_last_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [lp2c_pkg::COORD_W-1:0] o_point_x,
    output logic signed [lp2c_pkg::COORD_W-1:0] o_point_y,
    output logic                                o_point_valid,
    output logic                                o_last_out
);
    import lp2c_pkg::*;

    t_cfg  r_cfg;
    logic  w_adv;
    t_vec  w_x    [CORDIC_STEPS+1];
    t_vec  w_y    [CORDIC_STEPS+1];
    t_ang  w_z    [CORDIC_STEPS+1];
    t_side w_side [CORDIC_STEPS+1];

    assign w_adv      = !o_out_valid || !i_out_stall;
    assign o_in_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_angle     <= '0;
            r_cfg.angle_increment <= '0;
            r_cfg.min_range       <= '0;
            r_cfg.max_range       <= MAX_RANGE_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_START_ANGLE:     r_cfg.start_angle     <= i_cfg_data[ANGLE_W-1:0];
                REG_ANGLE_INCREMENT: r_cfg.angle_increment <= i_cfg_data[ANGLE_W-1:0];
                REG_MIN_RANGE:       r_cfg.min_range       <= i_cfg_data[RANGE_W-1:0];
                REG_MAX_RANGE:       r_cfg.max_range       <= i_cfg_data[RANGE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lp2c_front #(
        .MAX_BEAMS (MAX_BEAMS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_valid        (i_in_valid),
        .i_range_sample (i_range_sample),
        .i_beam_index   (i_beam_index),
        .i_last_in      (i_last_in),
        .i_cfg          (r_cfg),
        .o_x            (w_x[0]),
        .o_y            (w_y[0]),
        .o_z            (w_z[0]),
        .o_side         (w_side[0])
    );

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        lp2c_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .i_side  (w_side[g]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    lp2c_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_x           (w_x[CORDIC_STEPS]),
        .i_y           (w_y[CORDIC_STEPS]),
        .i_side        (w_side[CORDIC_STEPS]),
        .o_out_valid   (o_out_valid),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_point_valid (o_point_valid),
        .o_last_out    (o_last_out)
    );

endmodule

/* sv/lp2c_checker.sv */
`timescale 1ns / 1ps
`include "lidar_polar_to_cartesian_unit_macros.svh"

module lp2c_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [lp2c_pkg::COORD_W-1:0] o_point_x,
    input logic signed [lp2c_pkg::COORD_W-1:0] o_point_y,
    input logic                                o_point_valid
);
    import lp2c_pkg::*;

    localparam logic [COORD_W-1:0] COORD_BAD = {1'b1, {(COORD_W-1){1'b0}}};

    `LP2C_ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !o_out_valid, "output valid after reset")
    `LP2C_ASSERT_NOW(a_invalid_zero, i_clk, !i_rst_n, o_out_valid && !o_point_valid, o_point_x == '0 && o_point_y == '0, "invalid point with nonzero coordinates")
    `LP2C_ASSERT_NOW(a_coord_sat, i_clk, !i_rst_n, o_out_valid, o_point_x != COORD_BAD && o_point_y != COORD_BAD, "coordinate beyond saturation limit")
    `LP2C_ASSERT_NOW(a_backpressure, i_clk, !i_rst_n, o_out_valid && i_out_stall, o_in_stall, "request taken while output blocked")
    `LP2C_ASSERT_NEXT(a_hold, i_clk, !i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_point_x) && $stable(o_point_y), "stalled point changed")

endmodule

bind lidar_polar_to_cartesian_unit lp2c_checker u_lp2c_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_point_x     (o_point_x),
    .o_point_y     (o_point_y),
    .o_point_valid (o_point_valid)
);
